// ----- rtl/i2a_pkg.sv -----
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned FieldW  = 6;
  localparam int unsigned DigRegW = 80;   // 20 BCD digits, also holds 64 bits plus alignment
  localparam int unsigned NdigW   = 7;
  localparam int unsigned CntW    = 6;

  localparam logic [FieldW-1:0] MaxWidth = 6'd62;

  localparam logic [1:0] RadixBin = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixDec = 2'd2;
  localparam logic [1:0] RadixHex = 2'd3;

  localparam logic [NdigW-1:0] NdigBin = 7'd64;
  localparam logic [NdigW-1:0] NdigOct = 7'd22;
  localparam logic [NdigW-1:0] NdigDec = 7'd20;
  localparam logic [NdigW-1:0] NdigHex = 7'd16;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowA  = 8'h61;

  typedef enum logic [3:0] {
    StIdle,
    StDabble,
    StNorm,
    StPadCalc,
    StPfx0,
    StPfx1,
    StPadPre,
    StSign,
    StZeroPad,
    StDigit,
    StPadPost
  } state_e;

  typedef enum logic [2:0] {
    SelZero,
    SelX,
    SelSpace,
    SelSign,
    SelDigit
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      dabble;
    logic      norm;
    logic      calc_pad;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    logic iter_last;
    logic top_zero;
    logic ndig_one;
    logic pad_nz;
    logic pad_one;
    logic out_free;
    logic cnt_last;
    logic prefix;
    logic has_sign;
    logic left;
    logic zeros;
  } status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? ChUpA : ChLowA;
    if (d < 4'd10) begin
      digit_char = ChZero + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

// ----- rtl/i2a_datapath.sv -----
// Datapath: magnitude, BCD/digit shift register, counters and output register.
// Depends on i2a_pkg; driven by i2a_ctrl.
`timescale 1ns / 1ps

module i2a_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2a_pkg::cmd_t       cmd_i,
  output i2a_pkg::status_t    status_o,
  input  logic [63:0]         value_i,
  input  logic                narrow_i,
  input  logic                signed_conv_i,
  input  logic [1:0]          radix_sel_i,
  input  logic                upper_case_i,
  input  logic                ptr_prefix_i,
  input  logic                plus_flag_i,
  input  logic                left_align_i,
  input  logic                zero_fill_i,
  input  logic [5:0]          field_width_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                last_o
);
  import i2a_pkg::*;

  logic [ValueW-1:0]  mag_q, mag_d;
  logic [DigRegW-1:0] dig_q, dig_d;
  logic [NdigW-1:0]   ndig_q, ndig_d;
  logic [FieldW-1:0]  pad_q, pad_d;
  logic [FieldW-1:0]  width_q;
  logic [CntW-1:0]    iter_q, iter_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [1:0]         radix_q;
  logic               upper_q, prefix_q, left_q, zeros_q, has_sign_q, neg_q;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_char_q, out_char_d;
  logic               out_last_q;
  // set until the prefix '0' has been sent, so it is not counted as padding
  logic               pfx_zero_q, pfx_zero_d;

  logic [ValueW-1:0]  ext;
  logic               neg_in;
  logic [ValueW-1:0]  mag_in;
  logic [DigRegW-1:0] bcd_adj;
  logic [3:0]         top_dig;
  logic [NdigW-1:0]   len;
  logic [NdigW-1:0]   wid_sat;

  always_comb begin
    ext = narrow_i ? {{32{signed_conv_i & value_i[31]}}, value_i[31:0]} : value_i;
    neg_in = signed_conv_i & ext[63];
    mag_in = neg_in ? (64'd0 - ext) : ext;
  end

  always_comb begin
    for (int k = 0; k < DigRegW / 4; k++) begin
      bcd_adj[k*4 +: 4] = (dig_q[k*4 +: 4] >= 4'd5) ? dig_q[k*4 +: 4] + 4'd3
                                                    : dig_q[k*4 +: 4];
    end
  end

  always_comb begin
    case (radix_q)
      RadixBin: top_dig = {3'b0, dig_q[DigRegW-1]};
      RadixOct: top_dig = {1'b0, dig_q[DigRegW-1 -: 3]};
      default:  top_dig = dig_q[DigRegW-1 -: 4];
    endcase
  end

  assign len     = ndig_q + {{(NdigW-1){1'b0}}, has_sign_q};
  assign wid_sat = {1'b0, (width_q > MaxWidth) ? MaxWidth : width_q};

  always_comb begin
    mag_d       = mag_q;
    dig_d       = dig_q;
    ndig_d      = ndig_q;
    pad_d       = pad_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      mag_d  = mag_in;
      iter_d = '0;
      cnt_d  = '0;
      unique case (radix_sel_i)
        RadixBin: begin
          dig_d  = {mag_in, 16'b0};
          ndig_d = NdigBin;
        end
        RadixOct: begin
          dig_d  = {2'b0, mag_in, 14'b0};
          ndig_d = NdigOct;
        end
        RadixDec: begin
          dig_d  = '0;
          ndig_d = NdigDec;
        end
        default: begin
          dig_d  = {mag_in, 16'b0};
          ndig_d = NdigHex;
        end
      endcase
    end
    if (cmd_i.dabble) begin
      dig_d  = {bcd_adj[DigRegW-2:0], mag_q[ValueW-1]};
      mag_d  = {mag_q[ValueW-2:0], 1'b0};
      iter_d = iter_q + 1'b1;
    end
    if (cmd_i.norm || (cmd_i.emit && cmd_i.sel == SelDigit)) begin
      case (radix_q)
        RadixBin: dig_d = {dig_q[DigRegW-2:0], 1'b0};
        RadixOct: dig_d = {dig_q[DigRegW-4:0], 3'b0};
        default:  dig_d = {dig_q[DigRegW-5:0], 4'b0};
      endcase
      ndig_d = ndig_q - 1'b1;
    end
    if (cmd_i.calc_pad) begin
      pad_d = (wid_sat > len) ? FieldW'(wid_sat - len) : '0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      cnt_d       = cnt_q + 1'b1;
      if (cmd_i.sel == SelSpace || (cmd_i.sel == SelZero && zeros_q && !pfx_zero_q)) begin
        pad_d = pad_q - 1'b1;
      end
      case (cmd_i.sel)
        SelZero:  out_char_d = ChZero;
        SelX:     out_char_d = ChX;
        SelSpace: out_char_d = ChSpace;
        SelSign:  out_char_d = neg_q ? ChMinus : ChPlus;
        default:  out_char_d = digit_char(top_dig, upper_q);
      endcase
    end
  end

  assign pfx_zero_d = cmd_i.load ? ptr_prefix_i :
                      (cmd_i.emit && cmd_i.sel == SelZero) ? 1'b0 : pfx_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      cnt_q       <= '0;
      ndig_q      <= NdigHex;
      pad_q       <= '0;
      pfx_zero_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
      cnt_q       <= cnt_d;
      ndig_q      <= ndig_d;
      pad_q       <= pad_d;
      pfx_zero_q  <= pfx_zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    dig_q      <= dig_d;
    out_char_q <= out_char_d;
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.last;
    end
    if (cmd_i.load) begin
      radix_q    <= radix_sel_i;
      upper_q    <= upper_case_i;
      prefix_q   <= ptr_prefix_i;
      left_q     <= left_align_i;
      zeros_q    <= zero_fill_i & ~left_align_i;
      neg_q      <= neg_in;
      has_sign_q <= neg_in | (plus_flag_i & signed_conv_i);
      width_q    <= field_width_i;
    end
  end

  always_comb begin
    status_o.is_dec    = (radix_q == RadixDec);
    status_o.iter_last = (iter_q == {CntW{1'b1}});
    status_o.top_zero  = (top_dig == 4'd0);
    status_o.ndig_one  = (ndig_q == NdigW'(1));
    status_o.pad_nz    = (pad_q != '0);
    status_o.pad_one   = (pad_q == FieldW'(1));
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.cnt_last  = (cnt_q == {CntW{1'b1}});
    status_o.prefix    = prefix_q;
    status_o.has_sign  = has_sign_q;
    status_o.left      = left_q;
    status_o.zeros     = zeros_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  a_digit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.sel == SelDigit) || cmd_i.norm |-> ndig_q != '0)
    else $error("digit consumed with empty digit count");

  a_pad_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.sel == SelSpace |-> pad_q != '0)
    else $error("space padding with zero pad count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while held");

endmodule

// ----- rtl/i2a_ctrl.sv -----
// Controller: sequences conversion, digit normalization and character emission.
// Depends on i2a_pkg; commands i2a_datapath.
`timescale 1ns / 1ps

module i2a_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  i2a_pkg::status_t status_i,
  output i2a_pkg::cmd_t    cmd_o
);
  import i2a_pkg::*;

  state_e state_q, state_d;
  state_e body_first;
  logic   natural_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    if (!status_i.left && !status_i.zeros && status_i.pad_nz) begin
      body_first = StPadPre;
    end else if (status_i.has_sign) begin
      body_first = StSign;
    end else if (status_i.zeros && status_i.pad_nz) begin
      body_first = StZeroPad;
    end else begin
      body_first = StDigit;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.sel    = SelDigit;
    natural_last = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDabble;
        end
      end
      StDabble: begin
        if (!status_i.is_dec) begin
          state_d = StNorm;
        end else begin
          cmd_o.dabble = 1'b1;
          if (status_i.iter_last) begin
            state_d = StNorm;
          end
        end
      end
      StNorm: begin
        if (status_i.top_zero && !status_i.ndig_one) begin
          cmd_o.norm = 1'b1;
        end else begin
          state_d = StPadCalc;
        end
      end
      StPadCalc: begin
        cmd_o.calc_pad = 1'b1;
        state_d        = StPfx0;
      end
      default: begin
        unique case (state_q)
          StPfx0:    cmd_o.sel = SelZero;
          StPfx1:    cmd_o.sel = SelX;
          StPadPre:  cmd_o.sel = SelSpace;
          StSign:    cmd_o.sel = SelSign;
          StZeroPad: cmd_o.sel = SelZero;
          StPadPost: cmd_o.sel = SelSpace;
          default:   cmd_o.sel = SelDigit;
        endcase
        natural_last = (state_q == StDigit && status_i.ndig_one &&
                        !(status_i.left && status_i.pad_nz)) ||
                       (state_q == StPadPost && status_i.pad_one);
        if (state_q == StPfx0 && !status_i.prefix) begin
          state_d = body_first;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = natural_last || status_i.cnt_last;
          if (cmd_o.last) begin
            state_d = StIdle;
          end else begin
            unique case (state_q)
              StPfx0:    state_d = StPfx1;
              StPfx1:    state_d = body_first;
              StPadPre: begin
                if (status_i.pad_one) begin
                  state_d = status_i.has_sign ? StSign : StDigit;
                end
              end
              StSign:    state_d = (status_i.zeros && status_i.pad_nz) ? StZeroPad : StDigit;
              StZeroPad: begin
                if (status_i.pad_one) begin
                  state_d = StDigit;
                end
              end
              StDigit: begin
                if (status_i.ndig_one) begin
                  state_d = StPadPost;
                end
              end
              default:   state_d = state_q;
            endcase
          end
        end
      end
    endcase
  end

  a_cap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && status_i.cnt_last |-> cmd_o.last)
    else $error("64th character not marked last");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == StIdle)
    else $error("controller did not return to idle after last character");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StDabble)
    else $error("request accepted outside idle");

endmodule

// ----- rtl/integer_to_ascii_formatter_core.sv -----
// Top level of the integer to ASCII formatter: controller plus datapath.
// Depends on i2a_pkg, i2a_ctrl, i2a_datapath.
//
//  channel | signals                          | direction
//  in      | in_valid_i / in_ready_o, fields  | request with value and format flags
//  out     | out_valid_o / out_ready_i        | one character per transfer, last_o on final
//
// A request is taken only in idle. Decimal runs the double-dabble shift over all 64 value
// bits; other bases skip it. Leading-zero digits are dropped one per cycle (up to 63),
// then the pad count is computed. Characters leave one per cycle at best, at most 64 per
// request. The output register holds a character until taken; stalls only pause emission.
// Reset clears the controller and output valid; no memory is cleared.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic        narrow_i,
  input  logic        signed_conv_i,
  input  logic [1:0]  radix_sel_i,
  input  logic        upper_case_i,
  input  logic        ptr_prefix_i,
  input  logic        plus_flag_i,
  input  logic        left_align_i,
  input  logic        zero_fill_i,
  input  logic [5:0]  field_width_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);
  import i2a_pkg::*;

  cmd_t    cmd;
  status_t status;

  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2a_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (value_i),
    .narrow_i      (narrow_i),
    .signed_conv_i (signed_conv_i),
    .radix_sel_i   (radix_sel_i),
    .upper_case_i  (upper_case_i),
    .ptr_prefix_i  (ptr_prefix_i),
    .plus_flag_i   (plus_flag_i),
    .left_align_i  (left_align_i),
    .zero_fill_i   (zero_fill_i),
    .field_width_i (field_width_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .last_o        (last_o)
  );

endmodule
